### design/two_body_gravity_step_macros.svh
// Assertion macros used by the asserting file of the two-body step block.
`ifndef TWO_BODY_GRAVITY_STEP_MACROS_SVH
`define TWO_BODY_GRAVITY_STEP_MACROS_SVH
// Check that a condition implies a property on the same edge.
`define TBG_ASSERT_IMPL(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
// Check that a condition implies a property on the next edge.
`define TBG_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`endif

### design/tbg_pkg.sv
// Package with the sequencer states and status codes of the two-body step block.
`timescale 1ns / 1ps
package tbg_pkg;
  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_SQRT, ST_NUM, ST_DIVF, ST_MULT, ST_DIVA, ST_ADDV, ST_ADDP, ST_OUT
  } state_t;
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_COINCIDE = 2'd1;
  localparam logic [1:0] STATUS_SAT = 2'd2;
  // Item modes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;
  // Configuration register indexes.
  localparam logic [1:0] REG_GRAV = 2'd0;
  localparam logic [1:0] REG_MASS_A = 2'd1;
  localparam logic [1:0] REG_MASS_B = 2'd2;
endpackage

### design/two_body_gravity_step.sv
// Top level of the two-body semi-implicit Euler step block.
// Usage: the input channel (in_valid/in_stall) carries a load or a step item,
// and the output channel (out_valid/out_stall) returns both bodies and a status.
// A load item writes one body's position and velocity and goes straight to
// ST_OUT. A step item squares the offset, takes its integer square root one
// bit per cycle, and then for each of the four acceleration components
// divides G*m*2^F by S, multiplies that quotient by the offset magnitude with
// shift and add, and divides the product by the root, one bit per cycle in
// every pass. Coincident bodies skip the pull and go straight to the velocity
// and position updates. Only one item is in flight: the next item is taken
// only after the result is accepted. The result stays in output registers with
// out_valid high until out_stall is low. Reset clears the bodies to zero and
// the registers to 1.0, and drops out_valid. Configuration writes go through
// cfg_wen, cfg_index and cfg_data while the block is idle. The user must keep
// to this; the block itself does not enforce it.
`timescale 1ns / 1ps
module two_body_gravity_step import tbg_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic mode,
  input  logic body_sel,
  input  logic signed [WORD_BITS-1:0] load_pos_x,
  input  logic signed [WORD_BITS-1:0] load_pos_y,
  input  logic signed [WORD_BITS-1:0] load_vel_x,
  input  logic signed [WORD_BITS-1:0] load_vel_y,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [WORD_BITS-1:0] pos_a_x,
  output logic signed [WORD_BITS-1:0] pos_a_y,
  output logic signed [WORD_BITS-1:0] pos_b_x,
  output logic signed [WORD_BITS-1:0] pos_b_y,
  output logic signed [WORD_BITS-1:0] vel_a_x,
  output logic signed [WORD_BITS-1:0] vel_a_y,
  output logic signed [WORD_BITS-1:0] vel_b_x,
  output logic signed [WORD_BITS-1:0] vel_b_y,
  output logic [1:0] status,
  input  logic cfg_wen,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);
`include "two_body_gravity_step_macros.svh"
  localparam int W = WORD_BITS;
  localparam int SW = 2 * W + 2;          // square sum width
  localparam int NW = 64 + FRAC_BITS;     // G*m*2^F width
  localparam int TW = NW + W;             // f*|off| width
  localparam int RW = TW + 1;             // divider remainder width
  localparam int CW = $clog2(TW + 1);

  state_t state, state_next;
  logic [31:0] grav_constant, mass_a, mass_b;
  logic signed [W-1:0] pos [4];
  logic signed [W-1:0] vel [4];
  logic signed [W+1:0] acc [4];
  logic signed [W:0] off_x, off_y;
  logic [SW-1:0] sq_sum;
  logic [W:0] root;
  logic [TW-1:0] dividend, quot;
  logic [RW-1:0] rem;
  logic [SW-1:0] divisor;
  logic [CW-1:0] cnt;
  logic [1:0] comp;
  logic sat, coincide, pending;
  logic [NW-1:0] f_val;
  logic [W:0] mul_bits;

  // Offset magnitude of the current component.
  logic signed [W:0] off_cur;
  logic [W:0] mag_cur;
  always_comb begin
    off_cur = comp[0] ? off_y : off_x;
    if (comp[1]) off_cur = -off_cur;
    mag_cur = off_cur[W] ? -off_cur : off_cur;
  end

  // Shared shift-subtract unit: one trial subtraction per cycle.
  logic [RW-1:0] rem_sh, trial;
  logic take;
  logic [SW-1:0] sq_trial;
  logic [W:0] root_try;
  always_comb begin
    rem_sh = {rem[RW-2:0], dividend[TW-1]};
    trial = rem_sh - RW'(divisor);
    take = rem_sh >= RW'(divisor);
    root_try = root | ((W+1)'(1) << cnt);
    sq_trial = SW'(root_try) * SW'(root_try);
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid && !in_stall) state_next = (mode == MODE_STEP) ? ST_SQ : ST_OUT;
      ST_SQ:   state_next = (off_x == 0 && off_y == 0) ? ST_ADDV : ST_SQRT;
      ST_SQRT: if (cnt == 0) state_next = ST_NUM;
      ST_NUM:  state_next = ST_DIVF;
      ST_DIVF: if (cnt == 0) state_next = ST_MULT;
      ST_MULT: if (cnt == 0) state_next = ST_DIVA;
      ST_DIVA: if (cnt == 0) state_next = (comp == 2'd3) ? ST_ADDV : ST_NUM;
      ST_ADDV: state_next = ST_ADDP;
      ST_ADDP: state_next = ST_OUT;
      ST_OUT:  if (!pending) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_stall = (state != ST_IDLE) || out_valid;
  end

  // Saturating helpers.
  function automatic logic signed [W-1:0] clamp(input logic signed [W+2:0] v, output logic s);
    logic signed [W+2:0] hi, lo;
    hi = {4'b0000, {(W-1){1'b1}}};
    lo = -hi - 1;
    s = 1'b0;
    if (v > hi) begin s = 1'b1; clamp = hi[W-1:0]; end
    else if (v < lo) begin s = 1'b1; clamp = lo[W-1:0]; end
    else clamp = v[W-1:0];
  endfunction

  logic signed [W-1:0] nv [4];
  logic signed [W-1:0] np [4];
  logic [3:0] sv, sp;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      nv[i] = clamp((W+3)'(vel[i]) + (W+3)'(acc[i]), sv[i]);
      np[i] = clamp((W+3)'(pos[i]) + (W+3)'(vel[i]), sp[i]);
    end
  end

  // Quotient magnitude clamp for an acceleration component.
  logic [TW-1:0] qfin;
  logic qneg, qsat;
  logic signed [W+1:0] acc_val;
  always_comb begin
    qfin = {quot[TW-2:0], take};
    qneg = off_cur[W];
    qsat = qneg ? (qfin > TW'(1) << (W-1)) : (qfin > (TW'(1) << (W-1)) - 1);
    if (qsat) acc_val = qneg ? -((W+2)'(1) << (W-1)) : ((W+2)'(1) << (W-1)) - 1;
    else acc_val = qneg ? -(W+2)'(qfin[W:0]) : (W+2)'(qfin[W:0]);
  end

  // Sequencer registers and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      pending <= 1'b0;
      grav_constant <= 32'h0001_0000;
      mass_a <= 32'h0001_0000;
      mass_b <= 32'h0001_0000;
      for (int i = 0; i < 4; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_wen) begin
        unique case (cfg_index)
          REG_GRAV:   grav_constant <= cfg_data;
          REG_MASS_A: mass_a <= cfg_data;
          REG_MASS_B: mass_b <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: if (in_valid && !in_stall) begin
          sat <= 1'b0;
          coincide <= 1'b0;
          pending <= 1'b1;
          for (int i = 0; i < 4; i++) acc[i] <= '0;
          if (mode == MODE_LOAD) begin
            pos[{body_sel, 1'b0}] <= load_pos_x;
            pos[{body_sel, 1'b1}] <= load_pos_y;
            vel[{body_sel, 1'b0}] <= load_vel_x;
            vel[{body_sel, 1'b1}] <= load_vel_y;
          end
          off_x <= (W+1)'(pos[2]) - (W+1)'(pos[0]);
          off_y <= (W+1)'(pos[3]) - (W+1)'(pos[1]);
        end
        ST_SQ: begin
          sq_sum <= SW'(off_x) * SW'(off_x) + SW'(off_y) * SW'(off_y);
          coincide <= (off_x == 0 && off_y == 0);
          root <= '0;
          cnt <= CW'(W);
          comp <= 2'd0;
        end
        ST_SQRT: begin
          if (sq_trial <= sq_sum) root <= root_try;
          if (cnt != 0) cnt <= cnt - 1'b1;
        end
        ST_NUM: begin
          dividend <= TW'({64'(grav_constant) * 64'(comp[1] ? mass_a : mass_b),
                           FRAC_BITS'(0)}) << W;
          divisor <= sq_sum;
          rem <= '0;
          quot <= '0;
          cnt <= CW'(NW - 1);
        end
        ST_DIVF: begin
          // The dividend is fully shifted out by the last bit, leaving zero.
          rem <= take ? trial : rem_sh;
          quot <= {quot[TW-2:0], take};
          dividend <= dividend << 1;
          if (cnt == 0) begin
            f_val <= qfin[NW-1:0];
            mul_bits <= mag_cur;
            cnt <= CW'(W);
          end else cnt <= cnt - 1'b1;
        end
        ST_MULT: begin
          // Shift-and-add product f*|off|, one multiplier bit per cycle, MSB first.
          dividend <= (dividend << 1) + (mul_bits[W] ? TW'(f_val) : TW'(0));
          mul_bits <= mul_bits << 1;
          divisor <= SW'(root);
          rem <= '0;
          quot <= '0;
          if (cnt == 0) cnt <= CW'(TW - 1);
          else cnt <= cnt - 1'b1;
        end
        ST_DIVA: begin
          rem <= take ? trial : rem_sh;
          quot <= {quot[TW-2:0], take};
          dividend <= dividend << 1;
          if (cnt == 0) begin
            acc[comp] <= acc_val;
            if (qsat) sat <= 1'b1;
            comp <= comp + 1'b1;
          end else cnt <= cnt - 1'b1;
        end
        ST_ADDV: begin
          for (int i = 0; i < 4; i++) vel[i] <= nv[i];
          if (sv != 0) sat <= 1'b1;
        end
        ST_ADDP: begin
          for (int i = 0; i < 4; i++) pos[i] <= np[i];
          if (sp != 0) sat <= 1'b1;
        end
        ST_OUT: if (pending) begin
          pending <= 1'b0;
          out_valid <= 1'b1;
          pos_a_x <= pos[0]; pos_a_y <= pos[1]; pos_b_x <= pos[2]; pos_b_y <= pos[3];
          vel_a_x <= vel[0]; vel_a_y <= vel[1]; vel_b_x <= vel[2]; vel_b_y <= vel[3];
          status <= sat ? STATUS_SAT : (coincide ? STATUS_COINCIDE : STATUS_OK);
        end
        default: ;
      endcase
    end
  end

  // The block holds no new item while a result waits.
  `TBG_ASSERT_IMPL(a_busy_stall, out_valid, in_stall)
  // A result appears only after the sequencer has finished.
  `TBG_ASSERT_NEXT(a_out_after_seq, state == ST_OUT && pending, out_valid)
  // A step item never leads straight to idle.
  `TBG_ASSERT_NEXT(a_step_busy, state == ST_IDLE && in_valid && !in_stall && mode,
                   state == ST_SQ)
endmodule
